// ===== rtl/cac_pkg.sv =====
// Shared types, constants and helper functions for the row chroma aberration fixer.
// Used by cac_div and row_chroma_aberration_fix; depends on nothing else.
package cac_pkg;

	// Row store and field geometry.
	localparam int MaxRow      = 4096;
	localparam int AddrW       = $clog2(MaxRow);
	localparam int LenW        = AddrW + 1;
	localparam int SearchLimit = 100;
	localparam int ChW         = 16;
	localparam int PixW        = 3 * ChW;
	localparam int QW          = 32;
	localparam int CfgW        = 17;

	// Q16.16 constants.
	localparam logic [QW-1:0] OneQ16   = 32'h0001_0000;
	localparam logic [QW:0]   RecipNum = 33'h1_0000_0000;

	// Channel codes.
	typedef logic [1:0] ch_t;
	localparam ch_t ChRed   = 2'd0;
	localparam ch_t ChGreen = 2'd1;
	localparam ch_t ChBlue  = 2'd2;

	// Input operation codes.
	typedef enum logic [1:0] {
		OpLoad    = 2'd0,
		OpCorrect = 2'd1,
		OpRead    = 2'd2
	} op_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CfgGuide     = 2'd0,
		CfgThreshold = 2'd1,
		CfgMargin    = 2'd2,
		CfgRowLength = 2'd3
	} cfg_idx_t;

	// Request to the shared divider.
	typedef struct packed {
		logic          start;
		logic [QW:0]   num;
		logic [QW-1:0] den;
	} div_req_t;

	// Sequencer states.
	typedef enum logic [5:0] {
		ST_IDLE, ST_RD_OUT, ST_DIV_WAIT,
		ST_J_TOP, ST_E_RA, ST_E_RB, ST_E_RC, ST_E_T1, ST_E_T2,
		ST_G_TOP, ST_G_RA, ST_G_RB, ST_G_RC,
		ST_S_DIV, ST_S_INV, ST_S_ACC, ST_S_END,
		ST_B_RA, ST_B_RB, ST_B_RC, ST_B_A1, ST_B_A2, ST_B_B0, ST_B_B1, ST_B_B2,
		ST_B_IM, ST_B_MP, ST_B_IMP,
		ST_K_INIT, ST_K_RD, ST_K_DIV, ST_K_CMP, ST_K_WR
	} state_t;

	// Pixel layout: red in the top lane, blue in the bottom lane.
	function automatic logic [ChW-1:0] chan(input logic [PixW-1:0] p, input ch_t c);
		logic [ChW-1:0] v;
		case (c)
			ChRed:   v = p[3*ChW-1:2*ChW];
			ChGreen: v = p[2*ChW-1:ChW];
			default: v = p[ChW-1:0];
		endcase
		return v;
	endfunction

	function automatic logic [PixW-1:0] put_chan(input logic [PixW-1:0] p, input ch_t c,
			input logic [ChW-1:0] v);
		logic [PixW-1:0] r;
		r = p;
		case (c)
			ChRed:   r[3*ChW-1:2*ChW] = v;
			ChGreen: r[2*ChW-1:ChW] = v;
			default: r[ChW-1:0] = v;
		endcase
		return r;
	endfunction

	// Dividend of a Q16.16 ratio a/b.
	function automatic logic [QW:0] ratio_num(input logic [ChW-1:0] a);
		return {1'b0, a, 16'h0000};
	endfunction

endpackage

// ===== rtl/cac_div.sv =====
// Shared restoring divider: 33-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Depends on cac_pkg for the request struct and widths.
module cac_div
	import cac_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  div_req_t      req,
	output logic          done,
	output logic [QW-1:0] quo
);

	logic          busy_q;
	logic          done_q;
	logic [5:0]    cnt_q;
	logic [QW-1:0] rem_q;
	logic [QW:0]   nq_q;
	logic [QW-1:0] den_q;
	logic [QW:0]   shifted;
	logic [QW:0]   diff;
	logic          ge;

	// One restoring step: shift in the next dividend bit and try to subtract.
	assign shifted = {rem_q, nq_q[QW]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(QW);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	// Remainder and quotient shift register; a zero divisor counts as one.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			nq_q  <= req.num;
			den_q <= (req.den == '0) ? QW'(1) : req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[QW-1:0] : shifted[QW-1:0];
			nq_q  <= {nq_q[QW-1:0], ge};
		end
	end

	// Saturate quotients that reach 2^32.
	assign done = done_q;
	assign quo  = nq_q[QW] ? '1 : nq_q[QW-1:0];

endmodule

// ===== rtl/row_chroma_aberration_fix.sv =====
// Channel   | Handshake                   | Payload
// in        | in_valid / in_stall         | op, position, red_in, green_in, blue_in
// out       | out_valid / out_stall       | out_position, red_out, green_out, blue_out
// cfg       | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// A load writes the row store directly. A read goes through the registered read port of
// the row store to the output register, which frees the input side while the result
// waits. A correct command runs the row walk on one shared divider: it divides for each
// column tested, each channel step of edge growth and, per follower, each pixel clamped.
// Reset clears control and sets configuration to its defaults; the row store holds no reset value.
// Configuration writes are always taken (cfg_ready is high).
//
// Top level of the row chroma aberration fixer: row store, sequencer and output register.
// Depends on cac_pkg and cac_div.
module row_chroma_aberration_fix
	import cac_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       op,
	input  logic [AddrW-1:0] position,
	input  logic [ChW-1:0]   red_in,
	input  logic [ChW-1:0]   green_in,
	input  logic [ChW-1:0]   blue_in,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [AddrW-1:0] out_position,
	output logic [ChW-1:0]   red_out,
	output logic [ChW-1:0]   green_out,
	output logic [ChW-1:0]   blue_out,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [CfgW-1:0]  cfg_data
);

	state_t state_q, state_d, ret_q, ret_d;

	logic [1:0]      guide_q;
	logic [CfgW-1:0] thr_q;
	logic [CfgW-1:0] margin_q;
	logic [LenW-1:0] rowlen_q;

	ch_t             g_q, f1_q, f2_q, c_q;
	logic            inv_q, side_q, fol_q;
	logic [AddrW-1:0] j_q, lb_q, rb_q, k_q, rpos_q;
	logic [PixW-1:0] pa_q, pb_q;
	logic [QW-1:0]   best_q, m_q, im_q, mp_q, imp_q;
	logic [PixW-1:0] prod_s1;
	logic            wr_s1;

	logic [PixW-1:0] mem [MaxRow];
	logic [PixW-1:0] rd_q;
	logic            ram_re, ram_we;
	logic [AddrW-1:0] ram_addr;
	logic [PixW-1:0] ram_wdata;

	logic            out_valid_q;
	logic [AddrW-1:0] out_pos_q;
	logic [PixW-1:0] out_pix_q;

	div_req_t        div_req;
	logic            div_done;
	logic [QW-1:0]   div_quo;

	logic            in_acc, out_free;
	logic [LenW-1:0] len;
	ch_t             fcur, gsel;
	logic [AddrW-1:0] xcur;
	logic            left_go, right_go, jmore, krun;
	logic [QW-1:0]   thr32;
	logic [QW:0]     mp_sum;
	logic [PixW:0]   rnd;
	logic [ChW-1:0]  clamped;

	cac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Handshakes and common decode.
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign len      = (rowlen_q > LenW'(MaxRow)) ? LenW'(MaxRow) : rowlen_q;
	assign thr32    = QW'(thr_q);
	assign fcur     = fol_q ? f2_q : f1_q;
	assign xcur     = side_q ? rb_q : lb_q;
	assign jmore    = ({1'b0, j_q} + LenW'(2)) < len;
	assign left_go  = (lb_q != '0) && ((j_q - lb_q) <= AddrW'(SearchLimit));
	assign right_go = (({1'b0, rb_q} + LenW'(2)) < len) &&
		((rb_q - j_q) <= AddrW'(SearchLimit));
	assign krun     = k_q <= rb_q;
	assign mp_sum   = {1'b0, m_q} + (QW+1)'(margin_q);
	assign gsel     = (guide_q == 2'd3) ? ChRed : ch_t'(guide_q);

	// Rounded and saturated product for the clamp write.
	assign rnd     = {1'b0, prod_s1} + (PixW+1)'(32768);
	assign clamped = (rnd[PixW:ChW+16] != '0) ? '1 : rnd[ChW+15:16];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guide_q  <= 2'd1;
			thr_q    <= CfgW'(68813);
			margin_q <= CfgW'(6554);
			rowlen_q <= LenW'(4096);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CfgGuide:     guide_q  <= cfg_data[1:0];
				CfgThreshold: thr_q    <= cfg_data;
				CfgMargin:    margin_q <= cfg_data;
				CfgRowLength: rowlen_q <= cfg_data[LenW-1:0];
				default:      ;
			endcase
		end
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (op)
						OpCorrect: state_d = ST_J_TOP;
						OpRead:    state_d = ST_RD_OUT;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD_OUT:   if (out_free) state_d = ST_IDLE;
			ST_DIV_WAIT: if (div_done) state_d = ret_q;
			ST_J_TOP:    state_d = jmore ? ST_E_RA : ST_IDLE;
			ST_E_RA:     state_d = ST_E_RB;
			ST_E_RB:     state_d = ST_E_RC;
			ST_E_RC: begin
				state_d = ST_DIV_WAIT;
				ret_d   = ST_E_T1;
			end
			ST_E_T1: begin
				if (div_quo < thr32) begin
					state_d = ST_DIV_WAIT;
					ret_d   = ST_E_T2;
				end else begin
					state_d = ST_G_TOP;
				end
			end
			ST_E_T2:  state_d = (div_quo < thr32) ? ST_J_TOP : ST_G_TOP;
			ST_G_TOP: begin
				if (!side_q) state_d = left_go ? ST_G_RA : ST_G_TOP;
				else state_d = right_go ? ST_G_RA : ST_B_RA;
			end
			ST_G_RA: state_d = ST_G_RB;
			ST_G_RB: state_d = ST_G_RC;
			ST_G_RC: state_d = ST_S_DIV;
			ST_S_DIV: begin
				state_d = ST_DIV_WAIT;
				ret_d   = ST_S_INV;
			end
			ST_S_INV: begin
				if (inv_q) begin
					state_d = ST_DIV_WAIT;
					ret_d   = ST_S_ACC;
				end else begin
					state_d = ST_S_ACC;
				end
			end
			ST_S_ACC: state_d = (c_q == ChBlue) ? ST_S_END : ST_S_DIV;
			ST_S_END: begin
				if (best_q < thr32 && side_q) state_d = ST_B_RA;
				else state_d = ST_G_TOP;
			end
			ST_B_RA: state_d = ST_B_RB;
			ST_B_RB: state_d = ST_B_RC;
			ST_B_RC: begin
				state_d = ST_DIV_WAIT;
				ret_d   = ST_B_A1;
			end
			ST_B_A1: begin
				if (div_quo < OneQ16) begin
					state_d = ST_DIV_WAIT;
					ret_d   = ST_B_A2;
				end else begin
					state_d = ST_B_B0;
				end
			end
			ST_B_A2: state_d = ST_B_B0;
			ST_B_B0: begin
				state_d = ST_DIV_WAIT;
				ret_d   = ST_B_B1;
			end
			ST_B_B1: begin
				if (div_quo < OneQ16) begin
					state_d = ST_DIV_WAIT;
					ret_d   = ST_B_B2;
				end else begin
					state_d = ST_B_IM;
				end
			end
			ST_B_B2: state_d = ST_B_IM;
			ST_B_IM: begin
				state_d = ST_DIV_WAIT;
				ret_d   = ST_B_MP;
			end
			ST_B_MP:  state_d = ST_B_IMP;
			ST_B_IMP: begin
				state_d = ST_DIV_WAIT;
				ret_d   = ST_K_INIT;
			end
			ST_K_INIT: state_d = ST_K_RD;
			ST_K_RD: begin
				if (krun) state_d = ST_K_DIV;
				else state_d = fol_q ? ST_J_TOP : ST_B_RA;
			end
			ST_K_DIV: begin
				state_d = ST_DIV_WAIT;
				ret_d   = ST_K_CMP;
			end
			ST_K_CMP: state_d = ST_K_WR;
			ST_K_WR:  state_d = ST_K_RD;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Memory port and divider requests for each state.
	always_comb begin
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = '0;
		ram_wdata = {red_in, green_in, blue_in};
		div_req   = '0;
		unique case (state_q)
			ST_IDLE: begin
				ram_addr = position;
				if (in_acc && op == OpLoad) ram_we = 1'b1;
				if (in_acc && op == OpRead) ram_re = 1'b1;
			end
			ST_E_RA: begin
				ram_re   = 1'b1;
				ram_addr = j_q - AddrW'(1);
			end
			ST_E_RB: begin
				ram_re   = 1'b1;
				ram_addr = j_q + AddrW'(1);
			end
			ST_E_RC: begin
				div_req.start = 1'b1;
				div_req.num   = ratio_num(chan(rd_q, g_q));
				div_req.den   = QW'(chan(pa_q, g_q));
			end
			ST_E_T1: begin
				if (div_quo < thr32) begin
					div_req.start = 1'b1;
					div_req.num   = RecipNum;
					div_req.den   = div_quo;
				end
			end
			ST_G_RA: begin
				ram_re   = 1'b1;
				ram_addr = xcur - AddrW'(1);
			end
			ST_G_RB: begin
				ram_re   = 1'b1;
				ram_addr = xcur + AddrW'(1);
			end
			ST_S_DIV: begin
				div_req.start = 1'b1;
				div_req.num   = ratio_num(chan(pb_q, c_q));
				div_req.den   = QW'(chan(pa_q, c_q));
			end
			ST_S_INV: begin
				if (inv_q) begin
					div_req.start = 1'b1;
					div_req.num   = RecipNum;
					div_req.den   = div_quo;
				end
			end
			ST_B_RA: begin
				ram_re   = 1'b1;
				ram_addr = lb_q;
			end
			ST_B_RB: begin
				ram_re   = 1'b1;
				ram_addr = rb_q;
			end
			ST_B_RC: begin
				div_req.start = 1'b1;
				div_req.num   = ratio_num(chan(pa_q, fcur));
				div_req.den   = QW'(chan(pa_q, g_q));
			end
			ST_B_B0: begin
				div_req.start = 1'b1;
				div_req.num   = ratio_num(chan(pb_q, fcur));
				div_req.den   = QW'(chan(pb_q, g_q));
			end
			ST_B_A1, ST_B_B1: begin
				if (div_quo < OneQ16) begin
					div_req.start = 1'b1;
					div_req.num   = RecipNum;
					div_req.den   = div_quo;
				end
			end
			ST_B_IM: begin
				div_req.start = 1'b1;
				div_req.num   = RecipNum;
				div_req.den   = m_q;
			end
			ST_B_IMP: begin
				div_req.start = 1'b1;
				div_req.num   = RecipNum;
				div_req.den   = mp_q;
			end
			ST_K_RD: begin
				ram_re   = krun;
				ram_addr = k_q;
			end
			ST_K_DIV: begin
				div_req.start = 1'b1;
				div_req.num   = ratio_num(chan(rd_q, fcur));
				div_req.den   = QW'(chan(rd_q, g_q));
			end
			ST_K_WR: begin
				ram_we    = wr_s1;
				ram_addr  = k_q;
				ram_wdata = put_chan(rd_q, fcur, clamped);
			end
			default: ;
		endcase
	end

	// Row store with a registered read port.
	always_ff @(posedge clk) begin
		if (ram_we) mem[ram_addr] <= ram_wdata;
		if (ram_re) rd_q <= mem[ram_addr];
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	// Walk registers: column, span bounds, boundary ratios and clamp products.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rpos_q <= position;
				j_q    <= AddrW'(1);
				g_q    <= gsel;
				f1_q   <= (gsel == ChBlue) ? ChRed : ch_t'(gsel + 2'd1);
				f2_q   <= (gsel == ChRed) ? ChBlue : ch_t'(gsel - 2'd1);
			end
			ST_E_RB: pa_q <= rd_q;
			ST_E_T1: begin
				inv_q <= (div_quo < thr32);
				if (div_quo >= thr32) begin
					lb_q   <= j_q - AddrW'(1);
					side_q <= 1'b0;
				end
			end
			ST_E_T2: begin
				if (div_quo < thr32) begin
					j_q <= j_q + AddrW'(1);
				end else begin
					lb_q   <= j_q - AddrW'(1);
					side_q <= 1'b0;
				end
			end
			ST_G_TOP: begin
				if (!side_q && !left_go) begin
					side_q <= 1'b1;
					rb_q   <= j_q + AddrW'(1);
				end else if (side_q && !right_go) begin
					fol_q <= 1'b0;
				end
			end
			ST_G_RB: pa_q <= rd_q;
			ST_G_RC: begin
				pb_q   <= rd_q;
				c_q    <= ChRed;
				best_q <= '0;
			end
			ST_S_ACC: begin
				if (div_quo > best_q) best_q <= div_quo;
				c_q <= c_q + 2'd1;
			end
			ST_S_END: begin
				if (best_q < thr32) begin
					if (!side_q) begin
						side_q <= 1'b1;
						rb_q   <= j_q + AddrW'(1);
					end else begin
						fol_q <= 1'b0;
					end
				end else if (!side_q) begin
					lb_q <= lb_q - AddrW'(1);
				end else begin
					rb_q <= rb_q + AddrW'(1);
				end
			end
			ST_B_RB: pa_q <= rd_q;
			ST_B_RC: pb_q <= rd_q;
			ST_B_A1: if (div_quo >= OneQ16) m_q <= div_quo;
			ST_B_A2: m_q <= div_quo;
			ST_B_B1: if (div_quo >= OneQ16 && div_quo > m_q) m_q <= div_quo;
			ST_B_B2: if (div_quo > m_q) m_q <= div_quo;
			ST_B_MP: begin
				im_q <= div_quo;
				mp_q <= mp_sum[QW] ? '1 : mp_sum[QW-1:0];
			end
			ST_K_INIT: begin
				imp_q <= div_quo;
				k_q   <= lb_q;
			end
			ST_K_RD: begin
				if (!krun) begin
					if (!fol_q) fol_q <= 1'b1;
					else j_q <= rb_q + AddrW'(1);
				end
			end
			ST_K_CMP: begin
				if (div_quo > mp_q) begin
					prod_s1 <= m_q * chan(rd_q, g_q);
					wr_s1   <= 1'b1;
				end else if (div_quo < imp_q) begin
					prod_s1 <= im_q * chan(rd_q, g_q);
					wr_s1   <= 1'b1;
				end else begin
					wr_s1 <= 1'b0;
				end
			end
			ST_K_WR: k_q <= k_q + AddrW'(1);
			default: ;
		endcase
	end

	// Output register: a read result waits here until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RD_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD_OUT && out_free) begin
			out_pos_q <= rpos_q;
			out_pix_q <= rd_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_position = out_pos_q;
	assign red_out      = chan(out_pix_q, ChRed);
	assign green_out    = chan(out_pix_q, ChGreen);
	assign blue_out     = chan(out_pix_q, ChBlue);

	// Every divider start is followed by a wait for its quotient.
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> state_q == ST_DIV_WAIT)
		else $error("divider started without waiting for it");

	// A new result only comes from the read state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RD_OUT))
		else $error("result raised outside a read");

	// The store is never written or read while a quotient is pending.
	a_no_wr_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV_WAIT |-> !ram_we && !ram_re)
		else $error("store access during division");

endmodule
